FILE: design/sbfe_pkg.sv
package sbfe_pkg;

	// Input word selector carried on s_tuser
	typedef enum logic [1:0] {
		MODE_START   = 2'd0,
		MODE_PAYLOAD = 2'd1,
		MODE_REPLY   = 2'd2,
		MODE_UNUSED  = 2'd3
	} mode_t;

	// Output word kind carried on m_tuser
	typedef enum logic [1:0] {
		KIND_FRAME  = 2'd0,
		KIND_INFO   = 2'd1,
		KIND_REPORT = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	// Report status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_ILEN  = 3'd1;
	localparam logic [2:0] ST_BAD_CHECK = 3'd2;
	localparam logic [2:0] ST_BAD_CODE  = 3'd3;
	localparam logic [2:0] ST_BAD_RLEN  = 3'd4;

	// Frame constants
	localparam logic [7:0] NAD_T1     = 8'h21;
	localparam logic [7:0] NAD_TUN    = 8'h01;
	localparam logic [7:0] PCB_SEQ    = 8'h40;
	localparam logic [7:0] CLA_0      = 8'hA0;
	localparam logic [7:0] CLA_1      = 8'hCA;
	localparam logic [7:0] CLA_2      = 8'h00;
	localparam logic [7:0] CLA_3      = 8'h00;
	localparam logic [7:0] CLA_XOR    = CLA_0 ^ CLA_1 ^ CLA_2 ^ CLA_3;
	localparam logic [7:0] ILEN_MIN   = 8'd2;
	localparam logic [7:0] ILEN_MAX   = 8'd249;

	// Byte positions within an outgoing frame
	localparam logic [3:0] POS_NAD    = 4'd0;
	localparam logic [3:0] POS_PCB    = 4'd1;
	localparam logic [3:0] POS_LEN    = 4'd2;
	localparam logic [3:0] POS_CLA0   = 4'd3;
	localparam logic [3:0] POS_CLA1   = 4'd4;
	localparam logic [3:0] POS_CLA2   = 4'd5;
	localparam logic [3:0] POS_CLA3   = 4'd6;
	localparam logic [3:0] POS_LC     = 4'd7;
	localparam logic [3:0] POS_CMD    = 4'd8;
	localparam logic [3:0] POS_DATA   = 4'd9;
	localparam logic [3:0] POS_RLEN   = 4'd10;
	localparam logic [3:0] POS_CHK    = 4'd11;

	// Job queue, depth a power of two
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// Job classes handed from front to back
	typedef enum logic [1:0] {
		JOB_START  = 2'd0,
		JOB_BYTE   = 2'd1,
		JOB_INFO   = 2'd2,
		JOB_REPORT = 2'd3
	} job_kind_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] command_code;
		logic [7:0] info_length;
		logic [7:0] expected_response;
		logic [7:0] reply_length;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		job_kind_t  kind;
		logic       tail;
		logic       seq;
		logic [7:0] len_byte;
		logic [7:0] lc_byte;
		logic [7:0] cmd;
		logic [7:0] data;
		logic [7:0] rlen;
		logic [7:0] chk;
		logic [2:0] status;
		logic [15:0] status_word;
	} job_t;

endpackage

FILE: design/sbfe_front.sv
module sbfe_front import sbfe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     tunneled,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_item,
	input  logic     full,
	output logic     push,
	output job_t     push_job
);

	logic       seq_q;
	logic [7:0] send_chk_q;
	logic [7:0] pay_left_q;
	logic [7:0] rlen_q;
	logic [7:0] code_q;
	logic [7:0] rx_chk_q;
	logic [8:0] rx_cnt_q;
	logic [7:0] len_field_q;
	logic [7:0] code_seen_q;
	logic [7:0] sw_high_q;
	logic [7:0] sw_low_q;

	logic       acc;
	logic [7:0] ilen;
	logic       ilen_ok;
	logic [7:0] seq_byte;
	logic [7:0] hdr_xor;
	logic [7:0] pay_chk;
	logic [7:0] rx_chk_n;
	logic [7:0] code_seen_n;
	logic       idx_ge3;
	logic       at_sw_high;
	logic       at_sw_low;
	logic       at_end;
	logic [2:0] rx_status;

	assign in_ready = !full;
	assign acc      = in_valid && !full;
	assign ilen     = in_item.info_length;
	assign ilen_ok  = (ilen >= ILEN_MIN) && (ilen <= ILEN_MAX);
	assign seq_byte = seq_q ? PCB_SEQ : 8'h00;

	// XOR of all header bytes of a new frame
	always_comb begin
		if (tunneled) begin
			hdr_xor = NAD_TUN ^ CLA_XOR ^ (ilen + 8'd1) ^ in_item.command_code
				^ (ilen - 8'd2);
		end else begin
			hdr_xor = NAD_T1 ^ seq_byte ^ (ilen + 8'd6) ^ CLA_XOR ^ ilen
				^ in_item.command_code ^ (ilen - 8'd2);
		end
	end

	assign pay_chk = send_chk_q ^ in_item.data_byte;

	// Reply byte bookkeeping
	assign rx_chk_n    = ((rx_cnt_q == 9'd0) ? 8'h00 : rx_chk_q) ^ in_item.data_byte;
	assign code_seen_n = (rx_cnt_q == 9'd3) ? in_item.data_byte : code_seen_q;
	assign idx_ge3     = rx_cnt_q >= 9'd3;
	assign at_sw_high  = idx_ge3 && (rx_cnt_q == {1'b0, len_field_q} + 9'd1);
	assign at_sw_low   = idx_ge3 && (rx_cnt_q == {1'b0, len_field_q} + 9'd2);
	assign at_end      = idx_ge3 && (rx_cnt_q == {1'b0, len_field_q} + 9'd3);

	always_comb begin
		if (rx_chk_n != 8'h00) begin
			rx_status = ST_BAD_CHECK;
		end else if (code_seen_n != code_q) begin
			rx_status = ST_BAD_CODE;
		end else if (len_field_q < 8'd2 || (len_field_q - 8'd2) != rlen_q) begin
			rx_status = ST_BAD_RLEN;
		end else begin
			rx_status = ST_OK;
		end
	end

	// Classify the input word into a job
	always_comb begin
		push     = 1'b0;
		push_job = '0;
		case (in_item.mode)
			MODE_START: begin
				push = acc;
				if (ilen_ok) begin
					push_job.kind     = JOB_START;
					push_job.tail     = (ilen == ILEN_MIN);
					push_job.seq      = seq_q;
					push_job.len_byte = tunneled ? NAD_TUN : (ilen + 8'd6);
					push_job.lc_byte  = tunneled ? (ilen + 8'd1) : ilen;
					push_job.cmd      = in_item.command_code;
					push_job.data     = ilen - 8'd2;
					push_job.rlen     = in_item.reply_length;
					push_job.chk      = hdr_xor ^ in_item.reply_length;
				end else begin
					push_job.kind   = JOB_REPORT;
					push_job.status = ST_BAD_ILEN;
				end
			end
			MODE_PAYLOAD: begin
				push          = acc && (pay_left_q != 8'd0);
				push_job.kind = JOB_BYTE;
				push_job.tail = (pay_left_q == 8'd1);
				push_job.data = in_item.data_byte;
				push_job.rlen = rlen_q;
				push_job.chk  = pay_chk ^ rlen_q;
			end
			MODE_REPLY: begin
				if (at_end) begin
					push            = acc;
					push_job.kind   = JOB_REPORT;
					push_job.status = rx_status;
					if (rx_status == ST_OK) begin
						push_job.status_word = {sw_high_q, sw_low_q};
					end
				end else begin
					push          = acc && idx_ge3;
					push_job.kind = JOB_INFO;
					push_job.data = in_item.data_byte;
				end
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	// Advance protocol state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= 1'b0;
			send_chk_q  <= 8'h00;
			pay_left_q  <= 8'h00;
			rlen_q      <= 8'h00;
			code_q      <= 8'h00;
			rx_chk_q    <= 8'h00;
			rx_cnt_q    <= 9'd0;
			len_field_q <= 8'h00;
			code_seen_q <= 8'h00;
			sw_high_q   <= 8'h00;
			sw_low_q    <= 8'h00;
		end else if (acc) begin
			case (in_item.mode)
				MODE_START: begin
					if (!tunneled) begin
						seq_q <= !seq_q;
					end
					if (ilen_ok) begin
						send_chk_q <= (ilen == ILEN_MIN) ? (hdr_xor ^ in_item.reply_length)
							: hdr_xor;
						pay_left_q <= ilen - 8'd2;
						rlen_q     <= in_item.reply_length;
						code_q     <= in_item.expected_response;
						rx_cnt_q   <= 9'd0;
						rx_chk_q   <= 8'h00;
					end else begin
						pay_left_q <= 8'h00;
					end
				end
				MODE_PAYLOAD: begin
					if (pay_left_q != 8'd0) begin
						send_chk_q <= (pay_left_q == 8'd1) ? (pay_chk ^ rlen_q) : pay_chk;
						pay_left_q <= pay_left_q - 8'd1;
					end
				end
				MODE_REPLY: begin
					rx_chk_q    <= rx_chk_n;
					code_seen_q <= code_seen_n;
					if (rx_cnt_q == 9'd2) begin
						len_field_q <= in_item.data_byte;
					end
					if (at_sw_high) begin
						sw_high_q <= in_item.data_byte;
					end
					if (at_sw_low) begin
						sw_low_q <= in_item.data_byte;
					end
					rx_cnt_q <= at_end ? 9'd0 : (rx_cnt_q + 9'd1);
				end
				default: begin
					seq_q <= seq_q;
				end
			endcase
		end
	end

endmodule

FILE: design/sbfe_queue.sv
module sbfe_queue import sbfe_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output job_t head_job
);

	job_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full       = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_job   = slot_q[rd_q];

	// Hold job payloads
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("job pushed into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("job popped from empty queue");
	a_fill_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("fill count did not rise on push");
	a_fill_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(push == pop) |=> $stable(cnt_q)) else $error("fill count moved without cause");
`endif

endmodule

FILE: design/sbfe_back.sv
module sbfe_back import sbfe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  job_t        head_job,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,
	output logic [1:0]  m_tuser,
	output logic        m_tlast
);

	logic        started_q;
	logic [3:0]  pos_q;
	logic        m_tvalid_q;
	logic [1:0]  kind_q;
	logic [7:0]  byte_q;
	logic [2:0]  status_q;
	logic [15:0] sw_q;
	logic        last_q;

	logic        load;
	logic        is_frame;
	logic [3:0]  first_pos;
	logic [3:0]  last_pos;
	logic [3:0]  cur_pos;
	logic        is_last;
	logic [7:0]  frame_byte;
	kind_t       kind_n;
	logic [7:0]  byte_n;

	function automatic logic [3:0] tunneled_first(job_t j);
		// A tunneled frame has no PCB byte; the LEN slot carries the node byte
		return (j.len_byte == NAD_TUN && j.lc_byte == j.data + 8'd3) ? POS_LEN : POS_NAD;
	endfunction

	assign is_frame  = (head_job.kind == JOB_START) || (head_job.kind == JOB_BYTE);

	// Where the job's words start and end
	always_comb begin
		case (head_job.kind)
			JOB_START: first_pos = tunneled_first(head_job);
			JOB_BYTE:  first_pos = POS_DATA;
			default:   first_pos = POS_NAD;
		endcase
		if (is_frame) begin
			last_pos = head_job.tail ? POS_CHK : POS_DATA;
		end else begin
			last_pos = POS_NAD;
		end
	end

	assign cur_pos = started_q ? pos_q : first_pos;
	assign is_last = (cur_pos == last_pos);
	assign load    = head_valid && (!m_tvalid_q || m_tready);
	assign pop     = load && is_last;

	// Pick the frame byte at the current position
	always_comb begin
		case (cur_pos)
			POS_NAD:  frame_byte = NAD_T1;
			POS_PCB:  frame_byte = head_job.seq ? PCB_SEQ : 8'h00;
			POS_LEN:  frame_byte = head_job.len_byte;
			POS_CLA0: frame_byte = CLA_0;
			POS_CLA1: frame_byte = CLA_1;
			POS_CLA2: frame_byte = CLA_2;
			POS_CLA3: frame_byte = CLA_3;
			POS_LC:   frame_byte = head_job.lc_byte;
			POS_CMD:  frame_byte = head_job.cmd;
			POS_DATA: frame_byte = head_job.data;
			POS_RLEN: frame_byte = head_job.rlen;
			POS_CHK:  frame_byte = head_job.chk;
			default:  frame_byte = 8'h00;
		endcase
	end

	always_comb begin
		case (head_job.kind)
			JOB_START, JOB_BYTE: begin
				kind_n = KIND_FRAME;
				byte_n = frame_byte;
			end
			JOB_INFO: begin
				kind_n = KIND_INFO;
				byte_n = head_job.data;
			end
			default: begin
				kind_n = KIND_REPORT;
				byte_n = 8'h00;
			end
		endcase
	end

	// Step through the job and fill the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q  <= 1'b0;
			pos_q      <= POS_NAD;
			m_tvalid_q <= 1'b0;
			last_q     <= 1'b0;
		end else begin
			if (load) begin
				m_tvalid_q <= 1'b1;
				last_q     <= is_last;
				started_q  <= !is_last;
				pos_q      <= cur_pos + 4'd1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q   <= kind_n;
			byte_q   <= byte_n;
			status_q <= (head_job.kind == JOB_REPORT) ? head_job.status : ST_OK;
			sw_q     <= (head_job.kind == JOB_REPORT) ? head_job.status_word : 16'h0000;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = kind_q;
	assign m_tdata  = {5'b0, sw_q, status_q, byte_q};
	assign m_tlast  = last_q;

endmodule

FILE: design/smartcard_block_frame_engine_top.sv
// Channel   | Signals                                   | Word
// ----------+-------------------------------------------+----------------------------------
// s (in)    | s_tvalid s_tready s_tdata s_tuser         | one command, payload or reply byte
// m (out)   | m_tvalid m_tready m_tdata m_tuser m_tlast | one frame byte, info byte or report
// apb       | psel penable pwrite paddr pwdata prdata   | register 0: tunneled framing
//
// Input words are taken one per cycle while the four-entry job queue has room.
// Output words leave one per cycle while m_tready is high: a start word expands into
// 8 to 12 frame bytes, so the back end's byte sequencer sets the sustained rate for commands.
// Payload and reply words give at most one output word each (a last payload byte three).
// Reset clears all protocol state at once; no clearing pass is needed.
// Either side may stall alone: the queue and the output register decouple them.
module smartcard_block_frame_engine_top import sbfe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // command_code, info_length, expected_response,
	                               // reply_length, data_byte
	input  logic [1:0]  s_tuser,   // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // out_byte, status, status_word, zero fill
	output logic [1:0]  m_tuser,   // out_kind
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic     tunneled_q;
	in_item_t in_item;
	logic     full;
	logic     push;
	job_t     push_job;
	logic     pop;
	logic     head_valid;
	job_t     head_job;

	// Register port
	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'h0 : {31'h0, tunneled_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tunneled_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			tunneled_q <= pwdata[0];
		end
	end

	// Unpack the input word
	assign in_item.mode              = mode_t'(s_tuser);
	assign in_item.command_code      = s_tdata[7:0];
	assign in_item.info_length       = s_tdata[15:8];
	assign in_item.expected_response = s_tdata[23:16];
	assign in_item.reply_length      = s_tdata[31:24];
	assign in_item.data_byte         = s_tdata[39:32];

	sbfe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.tunneled (tunneled_q),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.full     (full),
		.push     (push),
		.push_job (push_job)
	);

	sbfe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	sbfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule
